### design/antialiased_line_rasterizer_unit_macros.svh
// Assertion macros shared by the line rasterizer RTL.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef ANTIALIASED_LINE_RASTERIZER_UNIT_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication
`define AAR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aar assertion failed");

// next-cycle implication
`define AAR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aar assertion failed");

`endif

### design/aar_pkg.sv
// Shared types, constants and helpers for the anti-aliased line rasterizer.
// No dependencies.
package aar_pkg;

	localparam int AAR_COORD_BITS = 16;
	localparam int AAR_COLOR_BITS = 32;
	localparam int AAR_ALPHA_BITS = 8;
	localparam int AAR_CFG_IDX_BITS = 3;

	localparam logic [AAR_ALPHA_BITS-1:0] AAR_ALPHA_HI = 8'hc0;
	localparam logic [AAR_ALPHA_BITS-1:0] AAR_ALPHA_LO = 8'h40;
	localparam logic [AAR_ALPHA_BITS-1:0] AAR_ALPHA_MAX = 8'd255;

	typedef enum logic [AAR_CFG_IDX_BITS-1:0] {
		REG_CLIP_LEFT = 3'd0,
		REG_CLIP_TOP = 3'd1,
		REG_CLIP_RIGHT = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_BRUSH_OPACITY = 3'd4,
		REG_LINE_COLOR = 3'd5
	} aar_reg_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SETUP = 8'b0000_0010,
		ST_ADV = 8'b0000_0100,
		ST_DIV = 8'b0000_1000,
		ST_SCALE_FG = 8'b0001_0000,
		ST_SCALE_BG = 8'b0010_0000,
		ST_CLIP = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} aar_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} aar_div_stat_t;

	// opacity * a / 255, exact for 8-bit operands
	function automatic logic [AAR_ALPHA_BITS-1:0] aar_scale(
		input logic [AAR_ALPHA_BITS-1:0] op,
		input logic [AAR_ALPHA_BITS-1:0] a
	);
		logic [2*AAR_ALPHA_BITS-1:0] p;
		logic [AAR_ALPHA_BITS-1:0] q0;
		logic [AAR_ALPHA_BITS:0] r;
		p = (2*AAR_ALPHA_BITS)'(op) * (2*AAR_ALPHA_BITS)'(a);
		q0 = p[2*AAR_ALPHA_BITS-1:AAR_ALPHA_BITS];
		r = {1'b0, p[AAR_ALPHA_BITS-1:0]} + {1'b0, q0};
		return q0 + ((r >= {1'b0, AAR_ALPHA_MAX}) ? 8'd1 : 8'd0);
	endfunction

endpackage

### design/aar_div.sv
// Iterative restoring divider: 8-bit quotient of (dividend * 256) / divisor.
// Depends on aar_pkg and the macro header; dividend must be below divisor.
`include "antialiased_line_rasterizer_unit_macros.svh"

module aar_div #(
	parameter int W = aar_pkg::AAR_COORD_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] dividend,
	input logic [W-1:0] divisor,
	output logic [aar_pkg::AAR_ALPHA_BITS-1:0] quotient,
	output aar_pkg::aar_div_stat_t stat
);
	import aar_pkg::*;

	localparam int CNT_BITS = $clog2(AAR_ALPHA_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(AAR_ALPHA_BITS - 1);

	logic [W-1:0] rem_q;
	logic [W-1:0] dvs_q;
	logic [AAR_ALPHA_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W:0] trial;
	logic [W:0] diff;
	logic fits;

	assign trial = {rem_q, 1'b0};
	assign diff = trial - {1'b0, dvs_q};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[AAR_ALPHA_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`AAR_ASSERT_IMP(a_div_no_restart, start, !busy_q)
	`AAR_ASSERT_IMP(a_div_rem_below, busy_q, rem_q < dvs_q)
	`AAR_ASSERT_NXT(a_div_done_after_last, busy_q && !start && cnt_q == CNT_LAST, done_q && !busy_q)

endmodule

### design/antialiased_line_rasterizer_unit.sv
// Two-ended anti-aliased line rasterizer, top level with sequencer.
// Start item: a single result unless it is a unit diagonal; the next item is taken once that result is emitted.
// Unit diagonal start: one result per kept corner, or a single status result if none is kept.
// Step item: once the restoring divider has produced the alpha quotient, one result per cycle
//   while out_ready allows it, up to four.
// A result waits on out_ready; arst_n clears sequencer, line and config.
`include "antialiased_line_rasterizer_unit_macros.svh"

module antialiased_line_rasterizer_unit #(
	parameter int COORD_BITS = aar_pkg::AAR_COORD_BITS,
	parameter int COLOR_BITS = aar_pkg::AAR_COLOR_BITS,
	parameter int CFG_BITS = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS
) (
	input logic clk,
	input logic arst_n,
	// configuration writes
	input logic cfg_we,
	input logic [aar_pkg::AAR_CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_BITS-1:0] cfg_data,
	// input items
	input logic in_valid,
	output logic in_ready,
	input logic command,
	input logic signed [COORD_BITS-1:0] x_first,
	input logic signed [COORD_BITS-1:0] y_first,
	input logic signed [COORD_BITS-1:0] x_second,
	input logic signed [COORD_BITS-1:0] y_second,
	// result items
	output logic out_valid,
	input logic out_ready,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic [aar_pkg::AAR_ALPHA_BITS-1:0] pixel_alpha,
	output logic drawn,
	output logic last_of_item,
	output logic line_done
);
	import aar_pkg::*;

	// one extra bit so neighbors and end-of-line moves never wrap
	localparam int CW = COORD_BITS + 1;
	localparam logic signed [CW-1:0] ONE_S = CW'(1);
	localparam logic signed [CW-1:0] MINUS_ONE_S = {CW{1'b1}};
	localparam logic [COORD_BITS-1:0] CLIP_MAX_RST = {1'b0, {(COORD_BITS-1){1'b1}}};

	// config registers
	logic signed [COORD_BITS-1:0] clip_l_q, clip_t_q, clip_r_q, clip_b_q;
	logic [AAR_ALPHA_BITS-1:0] opacity_q;
	logic [COLOR_BITS-1:0] color_q;

	// line state
	aar_state_t state_q;
	logic active_q, major_x_q, minor_neg_q;
	logic signed [CW-1:0] nx_q, ny_q, fx_q, fy_q;
	logic [COORD_BITS:0] dterm_q;         // stays below twice the major delta
	logic [COORD_BITS-1:0] maj_q, min_q;

	// per-item working registers
	logic diag_q, step_adv_q, done_q;
	logic [AAR_ALPHA_BITS-1:0] fg_raw_q, bg_raw_q, fg_q, bg_q;
	logic [3:0] mask_q;
	logic [1:0] k_q;

	// output register
	logic out_valid_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic [AAR_ALPHA_BITS-1:0] out_alpha_q;
	logic out_drawn_q, out_last_q, out_done_q;

	// decision term after the optional subtract, also the divider's dividend
	logic dterm_ge;
	logic [COORD_BITS:0] dterm_adj;
	logic signed [CW-1:0] s_off, nmaj, fmaj;

	// divider hookup
	logic div_start;
	logic [AAR_ALPHA_BITS-1:0] div_quo;
	aar_div_stat_t div_stat;

	aar_div #(
		.W(COORD_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dterm_adj[COORD_BITS-1:0]),
		.divisor(maj_q),
		.quotient(div_quo),
		.stat(div_stat)
	);

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_l_q <= '0;
			clip_t_q <= '0;
			clip_r_q <= CLIP_MAX_RST;
			clip_b_q <= CLIP_MAX_RST;
			opacity_q <= AAR_ALPHA_MAX;
			color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLIP_LEFT: clip_l_q <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_TOP: clip_t_q <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_RIGHT: clip_r_q <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_BOTTOM: clip_b_q <= cfg_data[COORD_BITS-1:0];
				REG_BRUSH_OPACITY: opacity_q <= cfg_data[AAR_ALPHA_BITS-1:0];
				REG_LINE_COLOR: color_q <= cfg_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- start setup: deltas and ordering ----------------
	logic signed [CW-1:0] dxs, dys, dxa, dya;
	logic [COORD_BITS-1:0] dx, dy;
	logic no_draw, is_diag, maj_x, swap;
	logic signed [CW-1:0] snx, sny, sfx, sfy;

	always_comb begin
		dxs = fx_q - nx_q;
		dys = fy_q - ny_q;
		dxa = dxs[CW-1] ? -dxs : dxs;
		dya = dys[CW-1] ? -dys : dys;
		dx = dxa[COORD_BITS-1:0];
		dy = dya[COORD_BITS-1:0];
		no_draw = (opacity_q == '0) || (dx == '0) || (dy == '0);
		is_diag = (dx == COORD_BITS'(1)) && (dy == COORD_BITS'(1));
		maj_x = dx >= dy;
		swap = maj_x ? (nx_q > fx_q) : (ny_q > fy_q);
		snx = swap ? fx_q : nx_q;
		sny = swap ? fy_q : ny_q;
		sfx = swap ? nx_q : fx_q;
		sfy = swap ? ny_q : fy_q;
	end

	// ---------------- step advance: decision term ----------------
	always_comb begin
		dterm_ge = dterm_q >= {1'b0, maj_q};
		dterm_adj = dterm_ge ? (dterm_q - {1'b0, maj_q}) : dterm_q;
		s_off = minor_neg_q ? MINUS_ONE_S : ONE_S;
		nmaj = major_x_q ? nx_q : ny_q;
		fmaj = major_x_q ? fx_q : fy_q;
	end

	assign div_start = (state_q == ST_ADV);

	// ---------------- candidate pixels ----------------
	// slot 0 near fg, 1 near bg, 2 far fg, 3 far bg; diagonal uses its own corners
	logic signed [CW-1:0] cx [4];
	logic signed [CW-1:0] cy [4];
	logic cf [4];

	always_comb begin
		cx[0] = nx_q; cy[0] = ny_q; cf[0] = 1'b1;
		if (diag_q) begin
			cx[1] = fx_q; cy[1] = fy_q; cf[1] = 1'b0;
			cx[2] = nx_q; cy[2] = fy_q; cf[2] = 1'b0;
			cx[3] = fx_q; cy[3] = ny_q; cf[3] = 1'b1;
		end else if (major_x_q) begin
			cx[1] = nx_q; cy[1] = ny_q + s_off; cf[1] = 1'b0;
			cx[2] = fx_q; cy[2] = fy_q; cf[2] = 1'b1;
			cx[3] = fx_q; cy[3] = fy_q - s_off; cf[3] = 1'b0;
		end else begin
			cx[1] = nx_q + s_off; cy[1] = ny_q; cf[1] = 1'b0;
			cx[2] = fx_q; cy[2] = fy_q; cf[2] = 1'b1;
			cx[3] = fx_q - s_off; cy[3] = fy_q; cf[3] = 1'b0;
		end
	end

	// clip test for the slot under k_q (one slot per cycle)
	logic signed [CW-1:0] cl_w, ct_w, cr_w, cb_w;
	logic in_clip, keep_far, slot_on;

	always_comb begin
		cl_w = CW'(clip_l_q);
		ct_w = CW'(clip_t_q);
		cr_w = CW'(clip_r_q);
		cb_w = CW'(clip_b_q);
		in_clip = (cx[k_q] >= cl_w) && (cx[k_q] <= cr_w) &&
			(cy[k_q] >= ct_w) && (cy[k_q] <= cb_w);
		// middle meeting: far end would repeat the near end
		keep_far = diag_q || (nmaj != fmaj);
		slot_on = (opacity_q != '0) && in_clip && (!k_q[1] || keep_far);
	end

	// emit: lowest pending slot goes first
	logic [1:0] sel;
	logic out_free, sel_last, emit_fire;

	always_comb begin
		if (mask_q[0]) sel = 2'd0;
		else if (mask_q[1]) sel = 2'd1;
		else if (mask_q[2]) sel = 2'd2;
		else sel = 2'd3;
		sel_last = (mask_q & (mask_q - 4'd1)) == 4'd0;
		out_free = !out_valid_q || out_ready;
	end

	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign in_ready = (state_q == ST_IDLE);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			major_x_q <= 1'b0;
			minor_neg_q <= 1'b0;
			nx_q <= '0;
			ny_q <= '0;
			fx_q <= '0;
			fy_q <= '0;
			dterm_q <= '0;
			maj_q <= '0;
			min_q <= '0;
			diag_q <= 1'b0;
			step_adv_q <= 1'b0;
			done_q <= 1'b0;
			fg_raw_q <= '0;
			bg_raw_q <= '0;
			fg_q <= '0;
			bg_q <= '0;
			mask_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_color_q <= '0;
			out_alpha_q <= '0;
			out_drawn_q <= 1'b0;
			out_last_q <= 1'b0;
			out_done_q <= 1'b0;
		end else begin
			if (emit_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						diag_q <= 1'b0;
						step_adv_q <= 1'b0;
						mask_q <= '0;
						if (!command) begin
							// start: latch raw endpoints, sort out next cycle
							nx_q <= CW'(x_first);
							ny_q <= CW'(y_first);
							fx_q <= CW'(x_second);
							fy_q <= CW'(y_second);
							state_q <= ST_SETUP;
						end else if (active_q) begin
							step_adv_q <= 1'b1;
							state_q <= ST_ADV;
						end else begin
							// step with no line: status only
							done_q <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SETUP: begin
					active_q <= 1'b0;
					if (no_draw) begin
						done_q <= 1'b1;
						state_q <= ST_EMIT;
					end else if (is_diag) begin
						diag_q <= 1'b1;
						done_q <= 1'b1;
						fg_raw_q <= AAR_ALPHA_HI;
						bg_raw_q <= AAR_ALPHA_LO;
						state_q <= ST_SCALE_FG;
					end else begin
						active_q <= 1'b1;
						major_x_q <= maj_x;
						nx_q <= snx;
						ny_q <= sny;
						fx_q <= sfx;
						fy_q <= sfy;
						dterm_q <= '0;
						maj_q <= maj_x ? dx : dy;
						min_q <= maj_x ? dy : dx;
						minor_neg_q <= maj_x ? (sfy < sny) : (sfx < snx);
						done_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_ADV: begin
					dterm_q <= dterm_adj;
					if (dterm_ge) begin
						if (major_x_q) begin
							ny_q <= ny_q + s_off;
							fy_q <= fy_q - s_off;
						end else begin
							nx_q <= nx_q + s_off;
							fx_q <= fx_q - s_off;
						end
					end
					// line ends once the two ends cross after this step
					done_q <= !((nmaj + ONE_S) <= (fmaj - ONE_S));
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						bg_raw_q <= div_quo;
						fg_raw_q <= AAR_ALPHA_MAX - div_quo;
						state_q <= ST_SCALE_FG;
					end
				end
				ST_SCALE_FG: begin
					fg_q <= aar_scale(opacity_q, fg_raw_q);
					state_q <= ST_SCALE_BG;
				end
				ST_SCALE_BG: begin
					bg_q <= aar_scale(opacity_q, bg_raw_q);
					k_q <= '0;
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					mask_q[k_q] <= slot_on;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_done_q <= done_q;
						if (mask_q == '0) begin
							out_x_q <= '0;
							out_y_q <= '0;
							out_color_q <= '0;
							out_alpha_q <= '0;
							out_drawn_q <= 1'b0;
							out_last_q <= 1'b1;
						end else begin
							out_x_q <= cx[sel][COORD_BITS-1:0];
							out_y_q <= cy[sel][COORD_BITS-1:0];
							out_color_q <= color_q;
							out_alpha_q <= cf[sel] ? fg_q : bg_q;
							out_drawn_q <= 1'b1;
							out_last_q <= sel_last;
							mask_q[sel] <= 1'b0;
						end
						if (mask_q == '0 || sel_last) begin
							// item finished: a step item also moves both ends one major position
							if (step_adv_q) begin
								if (major_x_q) begin
									nx_q <= nx_q + ONE_S;
									fx_q <= fx_q - ONE_S;
								end else begin
									ny_q <= ny_q + ONE_S;
									fy_q <= fy_q - ONE_S;
								end
								dterm_q <= dterm_q + {1'b0, min_q};
								active_q <= !done_q;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = out_x_q;
	assign pixel_y = out_y_q;
	assign pixel_color = out_color_q;
	assign pixel_alpha = out_alpha_q;
	assign drawn = out_drawn_q;
	assign last_of_item = out_last_q;
	assign line_done = out_done_q;

	`AAR_ASSERT_IMP(a_status_is_last, out_valid_q && !out_drawn_q, out_last_q)
	`AAR_ASSERT_IMP(a_div_only_in_div, div_stat.busy, state_q == ST_DIV)
	`AAR_ASSERT_IMP(a_adv_needs_line, state_q == ST_ADV, active_q && step_adv_q && maj_q != '0)

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for antialiased_line_rasterizer_unit.
// Depends on aar_pkg and the rasterizer RTL; a built-in predictor checks every result item.

module tb;
	import aar_pkg::*;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP = 1'b1;
	// index with no register behind it, writes must be dropped
	localparam logic [AAR_CFG_IDX_BITS-1:0] REG_UNUSED = 3'd6;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [AAR_CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic signed [15:0] x_first = '0, y_first = '0, x_second = '0, y_second = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] pixel_x, pixel_y;
	logic [31:0] pixel_color;
	logic [7:0] pixel_alpha;
	logic drawn, last_of_item, line_done;

	always #5 clk = ~clk;

	antialiased_line_rasterizer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
		.pixel_alpha(pixel_alpha), .drawn(drawn), .last_of_item(last_of_item),
		.line_done(line_done)
	);

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0] color;
		logic [7:0] alpha;
		logic drawn;
		logic last;
		logic done;
	} pixel_t;

	// directed row: typed = 1 means a single status item with done bit given here
	typedef struct packed {
		logic cmd;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
		logic typed;
		logic typed_done;
	} line_row_t;

	pixel_t pixels_due[$];
	pixel_t item_pixels[$];
	int errors = 0;
	int items_sent = 0;
	int pixels_seen = 0;
	bit idle_on = 1'b1;
	// set for the closing stretch: idling stays off
	bit flat_out = 1'b0;

	// predictor copy of config and line state
	longint clip_l = 0, clip_t = 0, clip_r = 32767, clip_b = 32767;
	int unsigned opacity = 255;
	logic [31:0] color_reg = '0;
	bit line_live = 0, x_major = 0, minor_neg = 0;
	longint near_px = 0, near_py = 0, far_px = 0, far_py = 0;
	longint err_acc = 0, span_major = 0, span_minor = 0;

	function automatic int unsigned scaled(int unsigned a);
		return (opacity * a) / 255;
	endfunction

	function automatic void plot(longint x, longint y, int unsigned a);
		pixel_t p;
		if (x < clip_l || x > clip_r || y < clip_t || y > clip_b)
			return;
		p.x = x[15:0];
		p.y = y[15:0];
		p.color = color_reg;
		p.alpha = a[7:0];
		p.drawn = 1'b1;
		p.last = 1'b0;
		p.done = 1'b0;
		item_pixels.push_back(p);
	endfunction

	function automatic void close_item(bit done);
		if (item_pixels.size() == 0)
			item_pixels.push_back('0);
		foreach (item_pixels[k])
			item_pixels[k].done = done;
		item_pixels[item_pixels.size()-1].last = 1'b1;
	endfunction

	function automatic void rasterize(logic cmd, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by);
		longint x1, y1, x2, y2, dx, dy, t, s;
		int unsigned back, fore;
		item_pixels.delete();
		if (cmd == CMD_START) begin
			x1 = ax; y1 = ay; x2 = bx; y2 = by;
			dx = (x2 > x1) ? x2 - x1 : x1 - x2;
			dy = (y2 > y1) ? y2 - y1 : y1 - y2;
			line_live = 0;
			if (opacity == 0 || dx == 0 || dy == 0) begin
				close_item(1);
				return;
			end
			if (dx == 1 && dy == 1) begin
				// single diagonal step: four corners
				plot(x1, y1, scaled(AAR_ALPHA_HI));
				plot(x2, y2, scaled(AAR_ALPHA_LO));
				plot(x1, y2, scaled(AAR_ALPHA_LO));
				plot(x2, y1, scaled(AAR_ALPHA_HI));
				close_item(1);
				return;
			end
			x_major = (dx >= dy);
			if ((x_major && x1 > x2) || (!x_major && y1 > y2)) begin
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
			end
			near_px = x1; near_py = y1; far_px = x2; far_py = y2;
			err_acc = 0;
			span_major = x_major ? dx : dy;
			span_minor = x_major ? dy : dx;
			minor_neg = x_major ? (y2 < y1) : (x2 < x1);
			line_live = 1;
			close_item(0);
			return;
		end
		if (!line_live) begin
			close_item(1);
			return;
		end
		s = minor_neg ? -1 : 1;
		if (err_acc >= span_major) begin
			err_acc -= span_major;
			if (x_major) begin near_py += s; far_py -= s; end
			else begin near_px += s; far_px -= s; end
		end
		back = 32'((err_acc * 256) / span_major);
		fore = scaled(255 - back);
		back = scaled(back);
		if (x_major) begin
			if (opacity != 0) begin
				plot(near_px, near_py, fore);
				plot(near_px, near_py + s, back);
				if (near_px != far_px) begin
					plot(far_px, far_py, fore);
					plot(far_px, far_py - s, back);
				end
			end
			near_px++; far_px--;
			line_live = (near_px <= far_px);
		end else begin
			if (opacity != 0) begin
				plot(near_px, near_py, fore);
				plot(near_px + s, near_py, back);
				if (near_py != far_py) begin
					plot(far_px, far_py, fore);
					plot(far_px - s, far_py, back);
				end
			end
			near_py++; far_py--;
			line_live = (near_py <= far_py);
		end
		err_acc += span_minor;
		close_item(!line_live);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	// result side: check against the oldest expectation
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_valid && out_ready) begin
			pixels_seen++;
			if (pixels_due.size() == 0) begin
				report("unexpected item", drawn, 0);
			end else begin
				e = pixels_due.pop_front();
				if (drawn !== e.drawn) report("drawn", drawn, e.drawn);
				if (pixel_x !== e.x) report("pixel_x", pixel_x, e.x);
				if (pixel_y !== e.y) report("pixel_y", pixel_y, e.y);
				if (pixel_color !== e.color) report("pixel_color", pixel_color, e.color);
				if (pixel_alpha !== e.alpha) report("pixel_alpha", pixel_alpha, e.alpha);
				if (last_of_item !== e.last) report("last_of_item", last_of_item, e.last);
				if (line_done !== e.done) report("line_done", line_done, e.done);
			end
		end
	end

	// receiver stalls in bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog: cycles with no item moving on either side
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("Watchdog expired with %0d items outstanding", pixels_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// send one item; typed rows replace the predicted items with the given status
	task automatic send(logic cmd, logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by, bit typed = 0, bit typed_done = 0);
		pixel_t st;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		x_first <= ax; y_first <= ay; x_second <= bx; y_second <= by;
		do @(posedge clk); while (!in_ready);
		rasterize(cmd, ax, ay, bx, by);
		if (typed) begin
			st = '0;
			st.last = 1'b1;
			st.done = typed_done;
			item_pixels.delete();
			item_pixels.push_back(st);
		end
		foreach (item_pixels[k])
			pixels_due.push_back(item_pixels[k]);
		items_sent++;
	endtask

	// sender holds off until every expected item is back, plus the block's tail
	task automatic drain();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(longint l, longint t, longint r, longint b, int unsigned op,
			logic [31:0] col);
		logic [31:0] vals[6];
		aar_reg_t idx;
		vals = '{l[31:0], t[31:0], r[31:0], b[31:0], op, col};
		for (int i = 0; i < 6; i++) begin
			idx = aar_reg_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[i];
			@(posedge clk);
		end
		// stray index, must change nothing
		cfg_index <= REG_UNUSED;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		clip_l = l; clip_t = t; clip_r = r; clip_b = b;
		opacity = op; color_reg = col;
	endtask

	function automatic logic signed [15:0] pick_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85) return 16'(int'($urandom_range(0, 70)) - 15);
		if (r < 95) return 16'($urandom);
		return (r & 1) ? 16'sh7fff : 16'sh8000;
	endfunction

	// well-formed lines with random content, sprinkled with stray steps
	task automatic random_lines(int count);
		int n;
		int steps;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				send(CMD_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				n++;
			end else begin
				send(CMD_START, pick_coord(), pick_coord(), pick_coord(), pick_coord());
				n++;
				steps = 0;
				while (line_live && steps < 40 && $urandom_range(0, 29) != 0) begin
					send(CMD_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
					steps++;
					n++;
				end
			end
			if (!flat_out && $urandom_range(0, 3) == 0)
				idle_on = !idle_on;
		end
	endtask

	line_row_t line_rows[] = '{
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1},         // step, no line
		'{CMD_START, 16'sd5, 16'sd5, 16'sd20, 16'sd5, 1'b1, 1'b1},       // no y extent
		'{CMD_START, 16'sd7, 16'sd3, 16'sd7, 16'sd9, 1'b1, 1'b1},        // no x extent
		'{CMD_START, 16'sd10, 16'sd10, 16'sd11, 16'sd11, 1'b0, 1'b0},    // unit diagonal
		'{CMD_START, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 1'b0, 1'b0},        // anti diagonal
		'{CMD_START, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1},        // point
		'{CMD_START, 16'sd2, 16'sd3, 16'sd9, 16'sd6, 1'b0, 1'b0},        // x major
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_STEP, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},        // ends cross, line done
		'{CMD_START, 16'sd20, 16'sd30, 16'sd17, 16'sd22, 1'b0, 1'b0},    // y major, endpoints swapped
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		// restart while active, neighbour reaches the top of the coordinate range
		'{CMD_START, 16'sd100, 16'sd32766, 16'sd105, 16'sh7fff, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_START, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0}, // full span
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
		'{CMD_START, 16'sh7fff, 16'sd0, 16'sh8000, 16'sd1, 1'b0, 1'b0},
		'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass on reset config
		foreach (line_rows[i])
			send(line_rows[i].cmd, line_rows[i].x1, line_rows[i].y1, line_rows[i].x2,
				line_rows[i].y2, line_rows[i].typed, line_rows[i].typed_done);
		drain();

		set_regs(4, 4, 40, 40, 128, $urandom);
		random_lines(80);
		drain();
		set_regs(-32768, -32768, 32767, 32767, 255, 32'hffffffff);
		random_lines(80);
		drain();
		// zero opacity: steps advance, nothing drawn
		set_regs(10, 10, 20, 20, 0, 32'h12345678);
		random_lines(60);
		drain();
		// empty clip rectangle
		set_regs(30, 5, 10, 40, 200, $urandom);
		random_lines(60);
		drain();
		set_regs(0, 0, 63, 63, 1, $urandom);
		random_lines(80);
		drain();
		// final stretch with both sides running flat out
		set_regs(-20, -20, 50, 50, 255, $urandom);
		flat_out = 1'b1;
		idle_on = 1'b0;
		random_lines(80);
		idle_on = 1'b0;
		drain();

		$display("Covered %0d input items and %0d result items over 6 clip/opacity/color settings",
			items_sent, pixels_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/aar_pkg.sv
design/aar_div.sv
design/antialiased_line_rasterizer_unit.sv
verif/tb.sv
